/* hw/rtl/lsoc_pkg.sv */
// ----------------------------------------------------------------------------
// lsoc_pkg: shared types, constants and the trig table
// Widths, register indexes, controller commands and the sine/cosine lookup.
// ----------------------------------------------------------------------------
package lsoc_pkg;

  localparam int BEAM_COUNT_DEF     = 360;
  localparam int TRIG_FRAC_BITS_DEF = 15;

  localparam int RANGE_W  = 16;
  localparam int BEAM_W   = 9;
  localparam int COORD_W  = 18;
  localparam int SUM_W    = 25;
  localparam int CNT_W    = 7;
  localparam int OUT_W    = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CNT_W-1:0] MAX_POINTS  = 7'd127;
  localparam logic [CNT_W-1:0] MAX_OBJECTS = 7'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RANGE   = 3'd0,
    REG_MAX_RANGE   = 3'd1,
    REG_JOIN_DIST   = 3'd2,
    REG_SECTOR_LOW  = 3'd3,
    REG_SECTOR_HIGH = 3'd4
  } reg_idx_t;

  // controller commands to the datapath
  typedef struct packed {
    logic capture;     // register input item and config-dependent tests
    logic coord;       // multiply range by trig values
    logic decide;      // gap / distance test, start/close decision
    logic close_start; // start divide of object sums by point count
    logic close_add;   // add divider result to centroid sums
    logic accum;       // add point to open object
    logic mean_start;  // start divide of centroid sums by object count
    logic emit;        // load output register
    logic clear;       // clear scan state
  } cmd_t;

  typedef struct packed {
    logic keep;        // captured beam is kept
    logic last;        // captured beam ends the scan
    logic do_close;    // an open object must be closed
    logic div_busy;    // divider working
    logic out_full;    // output register holds an item
  } stat_t;

  // shift-subtract quotient of two nonnegative values (elaboration only)
  function automatic longint cdiv(longint n, longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r << 1) | ((n >>> i) & longint'(1));
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | longint'(1);
      end
    end
    return q;
  endfunction

  // Taylor series in Q30, start term plus eight more terms (elaboration only)
  function automatic longint series(longint x, longint start, longint first);
    longint term;
    longint sum;
    longint a;
    term = start;
    sum  = start;
    a    = first;
    for (int n = 0; n < 8; n++) begin
      term = (term * x) >>> 30;
      term = (term * x) >>> 30;
      term = cdiv(term, a * (a + 1));
      a    = a + 2;
      if (n % 2 == 1) sum = sum + term;
      else sum = sum - term;
    end
    return sum;
  endfunction

  function automatic longint to_trig(longint q30, int fb);
    longint m;
    longint v;
    longint lim;
    longint d;
    d   = longint'(1) << (30 - fb);
    m   = (q30 < 0) ? -q30 : q30;
    v   = cdiv(m + (d >>> 1), d);
    lim = (longint'(1) << fb) - 1;
    if (v > lim) v = lim;
    return (q30 < 0) ? -v : v;
  endfunction

  // sel = 0 gives sine, 1 gives cosine, for phase already reduced
  function automatic longint trig_val(int phase, int bc, int fb, bit sel);
    longint q;
    longint r;
    longint x;
    longint ss;
    longint cc;
    longint so;
    longint co;
    q  = cdiv(longint'(4 * phase), longint'(bc));
    r  = 4 * phase - q * bc;
    x  = cdiv(64'd1686629713 * r, longint'(bc));
    ss = series(x, x, 2);
    cc = series(x, longint'(1) << 30, 1);
    case (q % 4)
      0: begin so = ss;  co = cc;  end
      1: begin so = cc;  co = -ss; end
      2: begin so = -ss; co = -cc; end
      default: begin so = -cc; co = ss; end
    endcase
    return sel ? to_trig(co, fb) : to_trig(so, fb);
  endfunction

endpackage

/* hw/rtl/lsoc_if.sv */
// ----------------------------------------------------------------------------
// lsoc_beam_if / lsoc_result_if: valid/ready channels
// Input beam channel and result channel with source and sink views.
// ----------------------------------------------------------------------------
interface lsoc_beam_if;
  logic                          valid;
  logic                          ready;
  logic [lsoc_pkg::RANGE_W-1:0]  range_mm;
  logic [lsoc_pkg::BEAM_W-1:0]   beam_index;
  logic                          last_beam;
  modport source (output valid, range_mm, beam_index, last_beam, input ready);
  modport sink   (input valid, range_mm, beam_index, last_beam, output ready);
endinterface

interface lsoc_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [lsoc_pkg::OUT_W-1:0] target_x_mm;
  logic signed [lsoc_pkg::OUT_W-1:0] target_y_mm;
  logic [lsoc_pkg::CNT_W-1:0]        object_count;
  modport source (output valid, target_x_mm, target_y_mm, object_count, input ready);
  modport sink   (input valid, target_x_mm, target_y_mm, object_count, output ready);
endinterface

/* hw/rtl/lidar_scan_object_centroids_unit.sv */
// ----------------------------------------------------------------------------
// lidar_scan_object_centroids_unit: front-sector object centroid finder
// Groups kept lidar beams into objects and reports the mean centroid per scan.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one beam per item (range_mm, beam_index, last_beam), valid/ready.
//   out : one item per scan on the last beam: mean centroid x/y and the
//         object count; zeros when no object was found.
//   cfg : write enable, index, data; write only while the block is idle.
// One item is worked on at a time. A kept beam that closes an object uses the
// shared bit-serial divider, one quotient bit per cycle for both sums. The
// last beam adds an end close and the mean division with emit; the next
// beam is taken only after the result register is loaded.
// Reset (synchronous, rst_n low) restores register defaults and clears the
// scan state. The result sits in an output register; while the receiver
// stalls, beams of the next scan are still taken, and only a new scan end
// waits for the register to drain.
// ----------------------------------------------------------------------------
module lidar_scan_object_centroids_unit #(
  parameter int BEAM_COUNT     = lsoc_pkg::BEAM_COUNT_DEF,
  parameter int TRIG_FRAC_BITS = lsoc_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lsoc_beam_if.sink                       in_ch,
  lsoc_result_if.source                   out_ch,
  input  logic                            cfg_we,
  input  logic [lsoc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lsoc_pkg::CFG_DAT_W-1:0]  cfg_data
);
  lsoc_pkg::cmd_t  cmd;
  lsoc_pkg::stat_t stat;
  logic            in_rdy;

  assign in_ch.ready = in_rdy;

  lsoc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_ch.valid && in_rdy), .in_rdy(in_rdy),
    .stat(stat), .cmd(cmd)
  );

  lsoc_datapath #(
    .BEAM_COUNT(BEAM_COUNT), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_range(in_ch.range_mm), .in_beam(in_ch.beam_index), .in_last(in_ch.last_beam),
    .cmd(cmd), .stat(stat),
    .out_pop(out_ch.ready),
    .out_x(out_ch.target_x_mm), .out_y(out_ch.target_y_mm), .out_cnt(out_ch.object_count)
  );

  assign out_ch.valid = stat.out_full;
endmodule

/* hw/rtl/lsoc_div.sv */
// ----------------------------------------------------------------------------
// lsoc_div: dual rounded divider
// Divides two signed sums by one 7-bit count, one quotient bit per cycle,
// rounding half away from zero.
// ----------------------------------------------------------------------------
module lsoc_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [lsoc_pkg::SUM_W-1:0]   num_a,
  input  logic signed [lsoc_pkg::SUM_W-1:0]   num_b,
  input  logic [lsoc_pkg::CNT_W-1:0]          den,
  output logic                                busy,
  output logic signed [lsoc_pkg::SUM_W-1:0]   quo_a,
  output logic signed [lsoc_pkg::SUM_W-1:0]   quo_b
);
  localparam int W  = lsoc_pkg::SUM_W;
  localparam int DW = lsoc_pkg::CNT_W;
  localparam int CW = $clog2(W + 2);

  logic [W-1:0]  ma_r, ma_nxt, mb_r, mb_nxt;     // dividend, shifts into quotient
  logic [DW:0]   ra_r, ra_nxt, rb_r, rb_nxt;     // partial remainders
  logic [DW-1:0] den_r;
  logic          na_r, nb_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;

  logic [W-1:0]  abs_a, abs_b;
  logic [W-1:0]  half;
  logic [DW+1:0] ta, tb;

  assign half  = W'(den >> 1);
  assign abs_a = (num_a < 0) ? W'(-num_a) : W'(num_a);
  assign abs_b = (num_b < 0) ? W'(-num_b) : W'(num_b);
  assign ta    = {ra_r, ma_r[W-1]};
  assign tb    = {rb_r, mb_r[W-1]};

  always_comb begin
    ma_nxt = ma_r; mb_nxt = mb_r; ra_nxt = ra_r; rb_nxt = rb_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r;
    if (start) begin
      ma_nxt   = abs_a + half;
      mb_nxt   = abs_b + half;
      ra_nxt   = '0;
      rb_nxt   = '0;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ta >= {2'b00, den_r}) begin
        ra_nxt = (DW+1)'(ta - {2'b00, den_r});
        ma_nxt = {ma_r[W-2:0], 1'b1};
      end else begin
        ra_nxt = ta[DW:0];
        ma_nxt = {ma_r[W-2:0], 1'b0};
      end
      if (tb >= {2'b00, den_r}) begin
        rb_nxt = (DW+1)'(tb - {2'b00, den_r});
        mb_nxt = {mb_r[W-2:0], 1'b1};
      end else begin
        rb_nxt = tb[DW:0];
        mb_nxt = {mb_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    ma_r <= ma_nxt; mb_r <= mb_nxt; ra_r <= ra_nxt; rb_r <= rb_nxt;
    if (start) begin
      den_r <= den;
      na_r  <= (num_a < 0);
      nb_r  <= (num_b < 0);
    end
  end

  assign busy  = busy_r;
  assign quo_a = na_r ? -$signed(ma_r) : $signed(ma_r);
  assign quo_b = nb_r ? -$signed(mb_r) : $signed(mb_r);
endmodule

/* hw/rtl/lsoc_datapath.sv */
// ----------------------------------------------------------------------------
// lsoc_datapath: beam conversion and object accumulation
// Holds config, scan state, trig lookup, multipliers and the divider.
// ----------------------------------------------------------------------------
module lsoc_datapath #(
  parameter int BEAM_COUNT     = lsoc_pkg::BEAM_COUNT_DEF,
  parameter int TRIG_FRAC_BITS = lsoc_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lsoc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [lsoc_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic [lsoc_pkg::RANGE_W-1:0]       in_range,
  input  logic [lsoc_pkg::BEAM_W-1:0]        in_beam,
  input  logic                               in_last,
  input  lsoc_pkg::cmd_t                     cmd,
  output lsoc_pkg::stat_t                    stat,
  input  logic                               out_pop,
  output logic signed [lsoc_pkg::OUT_W-1:0]  out_x,
  output logic signed [lsoc_pkg::OUT_W-1:0]  out_y,
  output logic [lsoc_pkg::CNT_W-1:0]         out_cnt
);
  localparam int TW  = TRIG_FRAC_BITS + 2;
  localparam int PW  = lsoc_pkg::RANGE_W + TW;
  localparam int CW  = lsoc_pkg::COORD_W;
  localparam int SW  = lsoc_pkg::SUM_W;
  localparam int NW  = lsoc_pkg::CNT_W;
  localparam int BW  = lsoc_pkg::BEAM_W;
  localparam int TBL_N = 1 << BW;
  localparam int DSW = 2 * CW + 1;

  // indexed by the raw beam index; the wrap modulo the beam count is folded in
  typedef logic signed [TW-1:0] trig_arr_t [TBL_N];

  function automatic trig_arr_t build(bit sel);
    trig_arr_t t;
    longint    ph;
    for (int i = 0; i < TBL_N; i++) begin
      ph   = longint'(i) - lsoc_pkg::cdiv(longint'(i), longint'(BEAM_COUNT)) * BEAM_COUNT;
      t[i] = TW'(lsoc_pkg::trig_val(int'(ph), BEAM_COUNT, TRIG_FRAC_BITS, sel));
    end
    return t;
  endfunction

  localparam trig_arr_t SIN_T = build(1'b0);
  localparam trig_arr_t COS_T = build(1'b1);

  // config
  logic [15:0] min_r, max_r;
  logic [11:0] join_r;
  logic [8:0]  slo_r, shi_r;

  // captured item
  logic [15:0]   rng_r;
  logic [BW-1:0] beam_r;
  logic          keep_r, last_r;
  logic signed [TW-1:0] sin_r, cos_r;

  logic signed [PW-1:0] px_r, py_r;
  logic signed [CW-1:0] x_r, y_r;

  // scan state
  logic signed [CW-1:0] prev_x_r, prev_y_r;
  logic [BW-1:0]        prev_beam_r;
  logic                 open_r;
  logic signed [SW-1:0] osx_r, osy_r, csx_r, csy_r;
  logic [NW-1:0]        opts_r, found_r;
  logic                 close_r;

  // output register
  logic                       ov_r;
  logic signed [lsoc_pkg::OUT_W-1:0] ox_r, oy_r;
  logic [NW-1:0]              oc_r;

  // divider
  logic                 div_start;
  logic signed [SW-1:0] div_a, div_b, qa, qb;
  logic [NW-1:0]        div_d;
  logic                 div_busy;

  logic [BW-1:0] gap;
  logic [CW-1:0] dx, dy;
  logic [DSW-1:0] d2;
  logic [23:0] j2;
  logic start_new;

  function automatic logic signed [CW-1:0] rnd(logic signed [PW-1:0] p);
    logic [PW-1:0] m;
    logic [PW-1:0] q;
    m = (p < 0) ? PW'(-p) : PW'(p);
    q = (m + PW'(1 << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
    return (p < 0) ? -$signed(CW'(q)) : $signed(CW'(q));
  endfunction

  assign gap = (beam_r > prev_beam_r) ? beam_r - prev_beam_r : prev_beam_r - beam_r;
  assign dx  = (x_r > prev_x_r) ? CW'(x_r - prev_x_r) : CW'(prev_x_r - x_r);
  assign dy  = (y_r > prev_y_r) ? CW'(y_r - prev_y_r) : CW'(prev_y_r - y_r);
  assign d2  = DSW'(dx * dx) + DSW'(dy * dy);
  assign j2  = join_r * join_r;
  assign start_new = !open_r || gap > BW'(1) || d2 > DSW'(j2) || opts_r >= lsoc_pkg::MAX_POINTS;

  assign div_start = cmd.close_start || cmd.mean_start;
  assign div_a = cmd.mean_start ? csx_r : osx_r;
  assign div_b = cmd.mean_start ? csy_r : osy_r;
  assign div_d = cmd.mean_start ? found_r : opts_r;

  lsoc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num_a(div_a), .num_b(div_b), .den(div_d),
    .busy(div_busy), .quo_a(qa), .quo_b(qb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= 16'd100; max_r <= 16'd3000; join_r <= 12'd50;
      slo_r <= 9'd52;   shi_r <= 9'd308;
    end else if (cfg_we) begin
      case (lsoc_pkg::reg_idx_t'(cfg_idx))
        lsoc_pkg::REG_MIN_RANGE:   min_r  <= cfg_data;
        lsoc_pkg::REG_MAX_RANGE:   max_r  <= cfg_data;
        lsoc_pkg::REG_JOIN_DIST:   join_r <= cfg_data[11:0];
        lsoc_pkg::REG_SECTOR_LOW:  slo_r  <= cfg_data[8:0];
        lsoc_pkg::REG_SECTOR_HIGH: shi_r  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rng_r  <= in_range;
      beam_r <= in_beam;
      last_r <= in_last;
      keep_r <= (in_beam < slo_r || in_beam > shi_r) && in_range > min_r && in_range < max_r;
      sin_r  <= SIN_T[in_beam];
      cos_r  <= COS_T[in_beam];
    end
    if (cmd.coord) begin
      px_r <= $signed({1'b0, rng_r}) * cos_r;
      py_r <= $signed({1'b0, rng_r}) * sin_r;
    end
    x_r <= rnd(px_r);
    y_r <= rnd(py_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      prev_x_r <= '0; prev_y_r <= '0; prev_beam_r <= '0; open_r <= 1'b0;
      osx_r <= '0; osy_r <= '0; opts_r <= '0;
      csx_r <= '0; csy_r <= '0; found_r <= '0; close_r <= 1'b0;
    end else begin
      if (cmd.decide) begin
        close_r <= open_r && start_new && opts_r != '0;
        if (start_new) begin
          // at the object limit the open object still closes, nothing reopens
          if (found_r < lsoc_pkg::MAX_OBJECTS) begin
            found_r <= found_r + 1'b1;
            open_r  <= 1'b1;
          end else begin
            open_r  <= 1'b0;
          end
        end
      end
      if (cmd.close_add) begin
        csx_r <= csx_r + qa; csy_r <= csy_r + qb;
        osx_r <= '0; osy_r <= '0; opts_r <= '0;
        close_r <= 1'b0;
      end
      if (cmd.accum) begin
        if (open_r) begin
          osx_r <= osx_r + SW'(x_r); osy_r <= osy_r + SW'(y_r);
          opts_r <= opts_r + 1'b1;
          prev_x_r <= x_r; prev_y_r <= y_r; prev_beam_r <= beam_r;
          close_r <= last_r;
        end else begin
          osx_r <= '0; osy_r <= '0; opts_r <= '0;
        end
      end
      if (cmd.capture && !(in_last)) close_r <= 1'b0;
      if (cmd.capture && in_last) close_r <= open_r && opts_r != '0;
    end
  end

  // at scan end close_r is loaded at capture; a kept last beam in an open object reloads it at accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.emit) ov_r <= 1'b1;
    else if (out_pop) ov_r <= 1'b0;
    if (cmd.emit) begin
      ox_r <= (found_r == '0) ? '0 : lsoc_pkg::OUT_W'(qa);
      oy_r <= (found_r == '0) ? '0 : lsoc_pkg::OUT_W'(qb);
      oc_r <= found_r;
    end
  end

  assign stat.keep     = keep_r;
  assign stat.last     = last_r;
  assign stat.do_close = close_r;
  assign stat.div_busy = div_busy;
  assign stat.out_full = ov_r;
  assign out_x   = ox_r;
  assign out_y   = oy_r;
  assign out_cnt = oc_r;
endmodule

/* hw/rtl/lsoc_ctrl.sv */
// ----------------------------------------------------------------------------
// lsoc_ctrl: sequencing state machine
// Steps one beam through capture, conversion, grouping and scan close.
// ----------------------------------------------------------------------------
module lsoc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  output logic            in_rdy,
  input  lsoc_pkg::stat_t stat,
  output lsoc_pkg::cmd_t  cmd
);
  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CHECK  = 11'b00000000010,
    S_ROUND  = 11'b00000000100,
    S_DECIDE = 11'b00000001000,
    S_CDIV   = 11'b00000010000,
    S_CWAIT  = 11'b00000100000,
    S_ACCUM  = 11'b00001000000,
    S_LAST   = 11'b00010000000,
    S_MWAIT  = 11'b00100000000,
    S_EMIT   = 11'b01000000000,
    S_MDIV   = 11'b10000000000
  } state_t;

  state_t st_r, st_nxt;
  logic   accum_pend_r, accum_pend_nxt;

  always_comb begin
    st_nxt = st_r;
    accum_pend_nxt = accum_pend_r;
    cmd = '0;
    in_rdy = 1'b0;
    case (st_r)
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.capture = 1'b1;
          st_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.coord = 1'b1;
        accum_pend_nxt = 1'b0;
        st_nxt = stat.keep ? S_ROUND : S_LAST;
      end
      S_ROUND: st_nxt = S_DECIDE;
      S_DECIDE: begin
        cmd.decide = 1'b1;
        accum_pend_nxt = 1'b1;
        st_nxt = S_CDIV;
      end
      S_CDIV: begin
        if (stat.do_close) begin
          cmd.close_start = 1'b1;
          st_nxt = S_CWAIT;
        end else if (accum_pend_r) begin
          st_nxt = S_ACCUM;
        end else begin
          st_nxt = S_MDIV;
        end
      end
      S_CWAIT: begin
        if (!stat.div_busy) begin
          cmd.close_add = 1'b1;
          st_nxt = accum_pend_r ? S_ACCUM : S_MDIV;
        end
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        accum_pend_nxt = 1'b0;
        st_nxt = S_LAST;
      end
      S_LAST: begin
        if (stat.last) st_nxt = S_CDIV;
        else st_nxt = S_IDLE;
      end
      S_MDIV: begin
        if (!stat.out_full) begin
          cmd.mean_start = 1'b1;
          st_nxt = S_MWAIT;
        end
      end
      S_MWAIT: if (!stat.div_busy) st_nxt = S_EMIT;
      S_EMIT: begin
        cmd.emit  = 1'b1;
        cmd.clear = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      accum_pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      accum_pend_r <= accum_pend_nxt;
    end
  end
endmodule
